// ===== rtl/wsd_pkg.sv =====
// ----------------------------------------------------------------------------
// wsd_pkg
// shared types and constants of the websocket frame deframer
// ----------------------------------------------------------------------------
package wsd_pkg;

    // default kept width of the frame payload length
    localparam int LENGTH_BITS_DEF = 32;

    // widths fixed by the result beat
    localparam int KIND_W    = 3;
    localparam int BYTE_W    = 8;
    localparam int MSG_LEN_W = 32;

    // event kinds on the result channel
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_BINARY  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CLOSE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PONG    = 3'd4;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 3'd5;

    // frame opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'ha;

    // seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
    localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

    // header byte counts
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] MASK_BYTES  = 4'd4;

    // event queue depth, power of two
    localparam int EVQ_DEPTH = 2;

    // one classified event from the parser
    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [BYTE_W-1:0]    data;
        logic [BYTE_W-1:0]    key;
        logic [MSG_LEN_W-1:0] length;
        logic                 binary;
        logic                 last;
    } event_t;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_frame_deframer
// receive-side websocket frame parser, one stream byte per beat in,
// header / payload / control events out
// ----------------------------------------------------------------------------
// channel   direction  payload                                    handshake
// s_        in         rx_byte                                    s_valid/s_ready
// m_        out        event_kind, payload_byte, message_length,  m_valid/m_ready
//                      binary_message, last_of_message
//
// one byte accepted per cycle while the event queue is not full, set by the parser step
// a result beat reaches m_ through two registers in order: queue entry, then the
// output register
// reset is synchronous and clears the parser, queue pointers and m_valid;
// no clearing pass
// s_ready drops only while the two-entry event queue is full, i.e. when
// m_ready has been held low
// after a close or error event all bytes are accepted and dropped until reset
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [wsd_pkg::BYTE_W-1:0]    s_rx_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wsd_pkg::KIND_W-1:0]    m_event_kind,
    output logic [wsd_pkg::BYTE_W-1:0]    m_payload_byte,
    output logic [wsd_pkg::MSG_LEN_W-1:0] m_message_length,
    output logic                          m_binary_message,
    output logic                          m_last_of_message
);
    import wsd_pkg::*;

    logic   s_accept;
    logic   ev_push;
    event_t ev_in;
    logic   ev_pop;
    logic   evq_full;
    logic   evq_not_empty;
    event_t ev_head;

    // input side only waits on queue space, never on the output register
    assign s_ready  = !evq_full;
    assign s_accept = s_valid && s_ready;

    // front: header parse and byte classification
    wsd_front #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .rx_byte (s_rx_byte),
        .ev_push (ev_push),
        .ev      (ev_in)
    );

    // decoupling queue, push and pop may share a cycle
    wsd_evq u_evq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (ev_push),
        .push_ev   (ev_in),
        .pop       (ev_pop),
        .full      (evq_full),
        .not_empty (evq_not_empty),
        .head_ev   (ev_head)
    );

    // back: unmask and present the result beat
    wsd_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ev_valid          (evq_not_empty),
        .ev                (ev_head),
        .ev_pop            (ev_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_kind      (m_event_kind),
        .m_payload_byte    (m_payload_byte),
        .m_message_length  (m_message_length),
        .m_binary_message  (m_binary_message),
        .m_last_of_message (m_last_of_message)
    );

endmodule

// ===== rtl/wsd_front.sv =====
// ----------------------------------------------------------------------------
// wsd_front
// header parser: takes one stream byte per beat and classifies it
// ----------------------------------------------------------------------------
module wsd_front #(
    parameter int LENGTH_BITS = wsd_pkg::LENGTH_BITS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        accept,
    input  logic [wsd_pkg::BYTE_W-1:0]  rx_byte,
    output logic                        ev_push,
    output wsd_pkg::event_t             ev
);
    import wsd_pkg::*;

    typedef enum logic [5:0] {
        PH_FIRST  = 6'b000001,
        PH_SECOND = 6'b000010,
        PH_EXTLEN = 6'b000100,
        PH_MASK   = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_SKIP   = 6'b100000
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic [3:0]             opcode_reg, opcode_next;
    logic                   mask_reg, mask_next;
    logic [31:0]            key_reg, key_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [1:0]             pos_reg, pos_next;
    logic                   bin_reg, bin_next;
    logic                   stopped_reg, stopped_next;

    logic                   len_done;
    logic                   hdr_done;
    logic                   mask_eff;
    logic [LENGTH_BITS-1:0] hdr_len;
    logic [LENGTH_BITS-1:0] rem_dec;
    logic [BYTE_W-1:0]      key_byte;

    assign rem_dec = rem_reg - LENGTH_BITS'(1);

    always_comb begin
        unique case (pos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next   = phase_reg;
        cnt_next     = cnt_reg;
        opcode_next  = opcode_reg;
        mask_next    = mask_reg;
        key_next     = key_reg;
        rem_next     = rem_reg;
        pos_next     = pos_reg;
        bin_next     = bin_reg;
        stopped_next = stopped_reg;
        len_done     = 1'b0;
        hdr_done     = 1'b0;
        mask_eff     = mask_reg;
        hdr_len      = rem_reg;
        ev_push      = 1'b0;
        ev           = '0;

        if (accept && !stopped_reg) begin
            unique case (phase_reg)
                PH_FIRST: begin
                    opcode_next = rx_byte[3:0];
                    phase_next  = PH_SECOND;
                end
                PH_SECOND: begin
                    mask_next = rx_byte[7];
                    mask_eff  = rx_byte[7];
                    cnt_next  = '0;
                    if (rx_byte[6:0] < LEN_CODE_EXT16) begin
                        hdr_len  = LENGTH_BITS'(rx_byte[6:0]);
                        len_done = 1'b1;
                    end else begin
                        cnt_next   = (rx_byte[6:0] == LEN_CODE_EXT16) ? EXT16_BYTES
                                                                      : EXT64_BYTES;
                        rem_next   = '0;
                        phase_next = PH_EXTLEN;
                    end
                end
                PH_EXTLEN: begin
                    // shift in big-endian, only the low bits survive
                    hdr_len  = {rem_reg[LENGTH_BITS-BYTE_W-1:0], rx_byte};
                    rem_next = hdr_len;
                    cnt_next = cnt_reg - 4'd1;
                    if (cnt_reg == 4'd1) begin
                        len_done = 1'b1;
                    end
                end
                PH_MASK: begin
                    key_next = {key_reg[23:0], rx_byte};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_reg == MASK_BYTES - 4'd1) begin
                        hdr_done = 1'b1;
                    end
                end
                PH_DATA: begin
                    pos_next    = pos_reg + 2'd1;
                    rem_next    = rem_dec;
                    ev_push     = 1'b1;
                    ev.kind     = KIND_PAYLOAD;
                    ev.data     = rx_byte;
                    ev.key      = mask_reg ? key_byte : '0;
                    ev.binary   = bin_reg;
                    ev.last     = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        phase_next = PH_FIRST;
                    end
                end
                PH_SKIP: begin
                    rem_next = rem_dec;
                    if (rem_dec == '0) begin
                        phase_next = PH_FIRST;
                    end
                end
                default: begin
                    phase_next = PH_FIRST;
                end
            endcase

            if (len_done) begin
                if (mask_eff) begin
                    phase_next = PH_MASK;
                    cnt_next   = '0;
                    key_next   = '0;
                    rem_next   = hdr_len;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                rem_next = hdr_len;
                pos_next = '0;
                cnt_next = '0;
                unique case (opcode_reg)
                    OP_TEXT, OP_BINARY: begin
                        bin_next   = (opcode_reg == OP_BINARY);
                        phase_next = (hdr_len != '0) ? PH_DATA : PH_FIRST;
                        ev_push    = 1'b1;
                        ev.kind    = (opcode_reg == OP_BINARY) ? KIND_BINARY : KIND_TEXT;
                        ev.length  = MSG_LEN_W'(hdr_len);
                        ev.binary  = (opcode_reg == OP_BINARY);
                        ev.last    = (hdr_len == '0);
                    end
                    OP_CLOSE: begin
                        stopped_next = 1'b1;
                        phase_next   = PH_FIRST;
                        ev_push      = 1'b1;
                        ev.kind      = KIND_CLOSE;
                    end
                    OP_PING: begin
                        phase_next = (hdr_len != '0) ? PH_SKIP : PH_FIRST;
                        ev_push    = 1'b1;
                        ev.kind    = KIND_PONG;
                    end
                    OP_PONG: begin
                        phase_next = (hdr_len != '0) ? PH_SKIP : PH_FIRST;
                    end
                    default: begin
                        stopped_next = 1'b1;
                        phase_next   = PH_FIRST;
                        ev_push      = 1'b1;
                        ev.kind      = KIND_ERROR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_FIRST;
            cnt_reg     <= '0;
            opcode_reg  <= '0;
            mask_reg    <= 1'b0;
            key_reg     <= '0;
            rem_reg     <= '0;
            pos_reg     <= '0;
            bin_reg     <= 1'b0;
            stopped_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            opcode_reg  <= opcode_next;
            mask_reg    <= mask_next;
            key_reg     <= key_next;
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            bin_reg     <= bin_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

// ===== rtl/wsd_evq.sv =====
// ----------------------------------------------------------------------------
// wsd_evq
// short event queue between parser and output stage
// ----------------------------------------------------------------------------
module wsd_evq (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  wsd_pkg::event_t push_ev,
    input  logic            pop,
    output logic            full,
    output logic            not_empty,
    output wsd_pkg::event_t head_ev
);
    import wsd_pkg::*;

    localparam int PTR_W = (EVQ_DEPTH > 1) ? $clog2(EVQ_DEPTH) : 1;
    localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

    event_t           entry_reg [EVQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(EVQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_ev   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_ev;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/wsd_back.sv =====
// ----------------------------------------------------------------------------
// wsd_back
// output stage: unmasks payload bytes and holds the result beat
// ----------------------------------------------------------------------------
module wsd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          ev_valid,
    input  wsd_pkg::event_t               ev,
    output logic                          ev_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wsd_pkg::KIND_W-1:0]    m_event_kind,
    output logic [wsd_pkg::BYTE_W-1:0]    m_payload_byte,
    output logic [wsd_pkg::MSG_LEN_W-1:0] m_message_length,
    output logic                          m_binary_message,
    output logic                          m_last_of_message
);
    import wsd_pkg::*;

    logic                 valid_reg;
    logic [KIND_W-1:0]    kind_reg;
    logic [BYTE_W-1:0]    byte_reg;
    logic [MSG_LEN_W-1:0] len_reg;
    logic                 bin_reg;
    logic                 last_reg;

    assign ev_pop = ev_valid && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ev_pop) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ev_pop) begin
            kind_reg <= ev.kind;
            byte_reg <= ev.data ^ ev.key;
            len_reg  <= ev.length;
            bin_reg  <= ev.binary;
            last_reg <= ev.last;
        end
    end

    assign m_valid           = valid_reg;
    assign m_event_kind      = kind_reg;
    assign m_payload_byte    = byte_reg;
    assign m_message_length  = len_reg;
    assign m_binary_message  = bin_reg;
    assign m_last_of_message = last_reg;

endmodule

// ===== rtl/wsd_checker.sv =====
// ----------------------------------------------------------------------------
// wsd_checker
// port-level checks of the deframer, attached by bind
// ----------------------------------------------------------------------------
module wsd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [wsd_pkg::KIND_W-1:0]    m_event_kind,
    input logic [wsd_pkg::BYTE_W-1:0]    m_payload_byte,
    input logic [wsd_pkg::MSG_LEN_W-1:0] m_message_length,
    input logic                          m_binary_message,
    input logic                          m_last_of_message
);
    import wsd_pkg::*;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind)
            && $stable(m_payload_byte) && $stable(m_message_length))
        else $error("result beat changed under stall");

    // only header events carry a length
    a_len_hdr_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != KIND_TEXT && m_event_kind != KIND_BINARY
            |-> m_message_length == '0)
        else $error("length on non-header event");

    // only payload events carry a byte
    a_byte_payload_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind != KIND_PAYLOAD |-> m_payload_byte == '0)
        else $error("byte on non-payload event");

    // control events carry no message flags
    a_ctrl_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_event_kind == KIND_CLOSE || m_event_kind == KIND_PONG
            || m_event_kind == KIND_ERROR)
            |-> !m_binary_message && !m_last_of_message)
        else $error("flags on control event");

    // nothing follows a delivered close or error
    a_stop_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && (m_event_kind == KIND_CLOSE || m_event_kind == KIND_ERROR)
            |=> !m_valid)
        else $error("event after close or error");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
